### rtl/core/msq_pkg.sv
// Shared constants and types for the maximal-square scanner.
package msq_pkg;

   localparam int MAX_COLS   = 1024;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int SIDE_W     = 11;
   localparam int WIDTH_W    = 11;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIDTH_W-1:0]    RESET_ROW_WIDTH = WIDTH_W'(MAX_COLS);
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_WIDTH   = CSR_ADDR_W'(0);

   typedef logic [COL_W-1:0]  col_type;
   typedef logic [SIDE_W-1:0] side_type;

   typedef struct packed {
      logic    valid;
      logic    cell_bit;
      logic    last_cell;
      logic    end_of_row;
      logic    first_row;
      col_type col;
   } cell_ctl_type;

endpackage

### rtl/core/msq_if.sv
// Stream interfaces for cell input and result output.
interface msq_req_if;
   logic valid;
   logic ready;
   logic cell_bit;
   logic last_cell;

   modport source (output valid, output cell_bit, output last_cell, input ready);
   modport sink (input valid, input cell_bit, input last_cell, output ready);
endinterface

interface msq_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [msq_pkg::SIDE_W-1:0] max_side;

   modport source (output valid, output max_side, input ready);
   modport sink (input valid, input max_side, output ready);
endinterface

### rtl/core/msq_line_ram.sv
// Single-port-write, registered-read line buffer memory.
module msq_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 11
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/msq_cell_eval.sv
// Cell value evaluation with left, diagonal and running-maximum registers.
module msq_cell_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  fire,
   input  msq_pkg::cell_ctl_type ctl,
   input  msq_pkg::side_type     above,
   output msq_pkg::side_type     value,
   output msq_pkg::side_type     peak
);

   msq_pkg::side_type left_ff, left_in;
   msq_pkg::side_type diag_ff, diag_in;
   msq_pkg::side_type max_ff, max_in;
   msq_pkg::side_type low2, low3;

   always_comb begin
      low2  = (left_ff < above) ? left_ff : above;
      low3  = (low2 < diag_ff) ? low2 : diag_ff;
      value = ctl.cell_bit ? msq_pkg::SIDE_W'(low3 + msq_pkg::SIDE_W'(1)) : '0;
      peak  = (value > max_ff) ? value : max_ff;

      left_in = left_ff;
      diag_in = diag_ff;
      max_in  = max_ff;
      if (clear) begin
         left_in = '0;
         diag_in = '0;
         max_in  = '0;
      end else if (fire) begin
         if (ctl.last_cell) begin
            left_in = '0;
            diag_in = '0;
            max_in  = '0;
         end else if (ctl.end_of_row) begin
            left_in = '0;
            diag_in = '0;
            max_in  = peak;
         end else begin
            left_in = value;
            diag_in = above;
            max_in  = peak;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         diag_ff <= '0;
         max_ff  <= '0;
      end else begin
         left_ff <= left_in;
         diag_ff <= diag_in;
         max_ff  <= max_in;
      end
   end

endmodule

### rtl/core/max_square_submatrix.sv
// Top level of the streaming largest all-ones square scanner.
//
//  port group | dir | handshake          | payload
//  req        | in  | valid / ready      | cell_bit, last_cell
//  rsp        | out | valid / ready      | max_side (11 bits)
//  csr_*      | in  | psel/penable/pready| row_width at byte address 0
//
// One cell per cycle unless stalled: the line buffer gives one read and one write per cycle.
// rsp.valid is set when the last cell leaves stage one; a waiting result holds it there.
// A same-column read-after-write (one-column rows) is forwarded around the memory.
// Reset is synchronous; the line buffer needs no clearing pass.
// req.ready drops only while a result waits in rsp and the next last cell sits in stage one.
module max_square_submatrix (
   input  logic                             clock,
   input  logic                             reset,
   msq_req_if.sink                          req,
   msq_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [msq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [msq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [msq_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   logic [msq_pkg::WIDTH_W-1:0] row_width_ff, row_width_in;
   msq_pkg::col_type            col_ff, col_in;
   logic                        first_row_ff, first_row_in;
   msq_pkg::cell_ctl_type       s1_ff, s1_in;
   logic                        fwd_ff, fwd_in;
   msq_pkg::side_type           fwd_val_ff, fwd_val_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   msq_pkg::side_type           max_side_ff, max_side_in;

   logic                        cfg_write;
   logic                        accept;
   logic                        stall;
   logic                        s1_fire;
   logic [msq_pkg::WIDTH_W-1:0] width_eff;
   msq_pkg::col_type            last_col;
   logic                        end_of_row;
   msq_pkg::side_type           rd_data;
   msq_pkg::side_type           above;
   msq_pkg::side_type           value;
   msq_pkg::side_type           peak;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == msq_pkg::REG_ROW_WIDTH);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == msq_pkg::REG_ROW_WIDTH)
                       ? msq_pkg::CSR_DATA_W'(row_width_ff) : '0;

   assign stall     = s1_ff.valid && s1_ff.last_cell && rsp_valid_ff && !rsp.ready;
   assign req.ready = !stall;
   assign accept    = req.valid && req.ready;
   assign s1_fire   = s1_ff.valid && !stall;

   always_comb begin
      width_eff = row_width_ff;
      if (row_width_ff == '0) begin
         width_eff = msq_pkg::WIDTH_W'(1);
      end else if (row_width_ff > msq_pkg::WIDTH_W'(msq_pkg::MAX_COLS)) begin
         width_eff = msq_pkg::WIDTH_W'(msq_pkg::MAX_COLS);
      end
      last_col   = msq_pkg::COL_W'(width_eff - msq_pkg::WIDTH_W'(1));
      end_of_row = (col_ff == last_col);
   end

   always_comb begin
      row_width_in = row_width_ff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (cfg_write) begin
         row_width_in = csr_pwdata[msq_pkg::WIDTH_W-1:0];
         col_in       = '0;
         first_row_in = 1'b1;
      end else if (accept) begin
         if (req.last_cell) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (end_of_row) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_ff + msq_pkg::COL_W'(1);
         end
      end

      s1_in = s1_ff;
      if (!stall) begin
         s1_in.valid      = accept;
         s1_in.cell_bit   = req.cell_bit;
         s1_in.last_cell  = req.last_cell;
         s1_in.end_of_row = end_of_row;
         s1_in.first_row  = first_row_ff;
         s1_in.col        = col_ff;
      end

      fwd_in     = fwd_ff;
      fwd_val_in = fwd_val_ff;
      if (accept) begin
         fwd_in     = s1_fire && (s1_ff.col == col_ff);
         fwd_val_in = value;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      max_side_in  = max_side_ff;
      if (s1_fire && s1_ff.last_cell) begin
         rsp_valid_in = 1'b1;
         max_side_in  = peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= msq_pkg::RESET_ROW_WIDTH;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         s1_ff        <= '0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         s1_ff        <= s1_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fwd_val_ff  <= fwd_val_in;
      max_side_ff <= max_side_in;
   end

   msq_line_ram #(
      .DEPTH (msq_pkg::MAX_COLS),
      .WIDTH (msq_pkg::SIDE_W)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.col),
      .wr_data (value)
   );

   assign above = s1_ff.first_row ? '0 : (fwd_ff ? fwd_val_ff : rd_data);

   msq_cell_eval u_cell_eval (
      .clock (clock),
      .reset (reset),
      .clear (cfg_write),
      .fire  (s1_fire),
      .ctl   (s1_ff),
      .above (above),
      .value (value),
      .peak  (peak)
   );

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.max_side = max_side_ff;

endmodule

### rtl/core/msq_checker.sv
// Port-level checks for the maximal-square scanner, bound to the top level.
module msq_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last_cell,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [msq_pkg::SIDE_W-1:0] rsp_max_side
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_side))
      else $error("result dropped or changed while stalled");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_cell |=> ##1 rsp_valid)
      else $error("no result two cycles after last cell transfer");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_cell, 2))
      else $error("result appeared without a last cell transfer");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

endmodule

bind max_square_submatrix msq_checker u_msq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_last_cell (req.last_cell),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_max_side  (rsp.max_side)
);

### tb/max_square_submatrix_tb.sv
// Self-checking testbench for the streaming largest all-ones square scanner.
`timescale 1ns / 1ps

module max_square_submatrix_tb;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          TARGET_CELLS   = 150;
   localparam int unsigned SIDE_LIMIT     = (1 << msq_pkg::SIDE_W) - 1;

   class side_scoreboard;
      msq_pkg::side_type           line_buf [msq_pkg::MAX_COLS];
      int unsigned                 left_v;
      int unsigned                 diag_v;
      int unsigned                 col;
      int unsigned                 run_max;
      bit                          first_row;
      logic [msq_pkg::WIDTH_W-1:0] width_reg;
      msq_pkg::side_type           expected_sides [$];
      int                          errors;
      int                          matrices;
      int                          cells;

      function new();
         width_reg = msq_pkg::RESET_ROW_WIDTH;
         errors    = 0;
         matrices  = 0;
         cells     = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         left_v    = 0;
         diag_v    = 0;
         col       = 0;
         first_row = 1'b1;
         run_max   = 0;
      endfunction

      function void set_width(logic [msq_pkg::WIDTH_W-1:0] value);
         width_reg = value;
         clear_scan();
      endfunction

      function int unsigned active_width();
         int unsigned w;
         w = 32'(width_reg);
         if (w == 0) w = 1;
         if (w > msq_pkg::MAX_COLS) w = msq_pkg::MAX_COLS;
         return w;
      endfunction

      function void note_cell(logic cell_val, logic last);
         int unsigned w;
         int unsigned above;
         int unsigned m;
         int unsigned v;
         int unsigned capped;
         w = active_width();
         cells++;
         if (col >= w) col = 0;
         above = first_row ? 0 : 32'(line_buf[msq_pkg::COL_W'(col)]);
         m = left_v;
         if (above < m) m = above;
         if (diag_v < m) m = diag_v;
         v = cell_val ? m + 1 : 0;
         line_buf[msq_pkg::COL_W'(col)] = msq_pkg::side_type'(v);
         diag_v = above;
         left_v = v;
         if (v > run_max) run_max = v;
         col++;
         if (col >= w) begin
            col       = 0;
            left_v    = 0;
            diag_v    = 0;
            first_row = 1'b0;
         end
         if (last) begin
            capped = (run_max > SIDE_LIMIT) ? SIDE_LIMIT : run_max;
            expected_sides = {expected_sides, msq_pkg::side_type'(capped)};
            matrices++;
            clear_scan();
         end
      endfunction

      function void check_side(msq_pkg::side_type got);
         msq_pkg::side_type want;
         if (expected_sides.size() == 0) begin
            $display("%0t: unexpected max_side, expected none, actual %0d", $time, got);
            errors++;
         end else begin
            want = expected_sides.pop_front();
            if (got !== want) begin
               $display("%0t: max_side mismatch, expected %0d, actual %0d", $time, want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [msq_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [msq_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [msq_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   msq_req_if req ();
   msq_rsp_if rsp ();

   side_scoreboard sb;
   bit             quiet;
   int unsigned    idle_cycles;
   int unsigned    rsp_stall;
   int unsigned    width_writes;

   max_square_submatrix DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            sb.note_cell(req.cell_bit, req.last_cell);
         end
         if (rsp.valid && rsp.ready) begin
            sb.check_side(rsp.max_side);
            rsp_stall = quiet ? 0 : $urandom_range(0, 3);
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr_psel && csr_penable)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("max_square_submatrix_tb failed");
            $finish;
         end
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0) begin
            rsp.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   task automatic send_cell(input logic cell_val, input logic last);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.cell_bit  <= cell_val;
      req.last_cell <= last;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic send_matrix(input int unsigned count, input int unsigned density,
                              input bit close);
      for (int unsigned i = 0; i < count; i++) begin
         send_cell($urandom_range(1, 100) <= density, close && (i == count - 1));
      end
   endtask

   // hold until every result has arrived and the pipeline has emptied
   task automatic settle();
      req.valid <= 1'b0;
      while (sb.expected_sides.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic change_row_width(input logic [msq_pkg::CSR_DATA_W-1:0] data);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= msq_pkg::REG_ROW_WIDTH;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_width(data[msq_pkg::WIDTH_W-1:0]);
      width_writes++;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[msq_pkg::WIDTH_W-1:0] !== data[msq_pkg::WIDTH_W-1:0]) begin
         $display("%0t: row_width readback mismatch, expected %0d, actual %0d",
                  $time, data[msq_pkg::WIDTH_W-1:0], csr_prdata[msq_pkg::WIDTH_W-1:0]);
         sb.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int unsigned                    sel;
      int unsigned                    w;
      int unsigned                    rows;
      int unsigned                    count;
      int unsigned                    density;
      int unsigned                    kind;
      int unsigned                    budget;
      int                             start_cells;
      int                             phase_cells;
      logic [msq_pkg::CSR_DATA_W-1:0] data;

      sb            = new();
      reset         = 1'b1;
      req.valid     = 1'b0;
      req.cell_bit  = 1'b0;
      req.last_cell = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      quiet         = 1'b0;
      idle_cycles   = 0;
      rsp_stall     = 0;
      width_writes  = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_matrix(1, 100, 1);
      send_matrix(1, 0, 1);
      send_matrix(msq_pkg::MAX_COLS + 8, 100, 1);
      change_row_width(3);
      send_matrix(9, 100, 1);
      send_matrix(7, 100, 1);
      send_matrix(9, 0, 1);
      change_row_width(0);
      send_matrix(4, 100, 1);
      change_row_width(2047);
      send_matrix(5, 100, 1);
      change_row_width(msq_pkg::MAX_COLS + 1);
      send_matrix(3, 60, 1);
      change_row_width(1);
      send_matrix(3, 100, 1);
      change_row_width(4);
      send_matrix(6, 100, 0);
      change_row_width(4);
      send_matrix(16, 100, 1);

      start_cells = sb.cells;
      while (sb.cells - start_cells < TARGET_CELLS) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) w = $urandom_range(1, 12);
         else if (sel < 8) w = $urandom_range(13, 40);
         else if (sel == 8) w = 0;
         else w = $urandom_range(msq_pkg::MAX_COLS, 2047);
         data = $urandom();
         data[msq_pkg::WIDTH_W-1:0] = msq_pkg::WIDTH_W'(w);
         change_row_width(data);
         quiet = ($urandom_range(0, 3) == 0);
         budget = $urandom_range(40, 120);
         phase_cells = sb.cells;
         while (sb.cells - phase_cells < budget) begin
            w = sb.active_width();
            kind = $urandom_range(0, 9);
            if (kind < 6) density = $urandom_range(80, 100);
            else if (kind < 8) density = $urandom_range(20, 70);
            else density = 100 * $urandom_range(0, 1);
            if (w > 64) begin
               count = $urandom_range(1, 40);
            end else if (kind == 9) begin
               count = $urandom_range(1, 3 * w);
               density = 50;
            end else begin
               rows = $urandom_range(1, (w + 2 < 12) ? w + 2 : 12);
               count = (rows - 1) * w;
               count += ($urandom_range(0, 3) == 0) ? $urandom_range(1, w) : w;
            end
            send_matrix(count, density, 1);
         end
         if ($urandom_range(0, 3) == 0) begin
            send_matrix($urandom_range(1, 40), 70, 0);
         end
      end

      settle();
      $display("covered %0d cells in %0d matrices over %0d row_width writes",
               sb.cells, sb.matrices, width_writes);
      $display("widths from 0 to 2047, mid-matrix drops, short last rows, random idling");
      if (sb.errors == 0) begin
         $display("max_square_submatrix_tb passed");
      end else begin
         $display("max_square_submatrix_tb failed");
      end
      $finish;
   end

endmodule

### max_square_submatrix.f
rtl/core/msq_pkg.sv
rtl/core/msq_if.sv
rtl/core/msq_line_ram.sv
rtl/core/msq_cell_eval.sv
rtl/core/max_square_submatrix.sv
rtl/core/msq_checker.sv
tb/max_square_submatrix_tb.sv
